// ===== sv/xpbd_pkg.sv =====
// Shared types, constants and helpers for the XPBD distance-constraint solver.
// Holds the table entry layouts, command and status codes and saturation.
// No dependencies.
package xpbd_pkg;

  localparam int PARTICLES     = 1024;
  localparam int CONSTRAINTS   = 4096;
  localparam int FRACTION_BITS = 16;

  localparam int PIDX_W = $clog2(PARTICLES);
  localparam int CIDX_W = $clog2(CONSTRAINTS);

  localparam int IN_TDATA_W  = 192;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 104;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 31;
  localparam int DIV_W       = 64;

  localparam logic [30:0] ALPHA_MAX     = 31'h7FFF_FFFF;
  localparam logic [30:0] SUBSTEP_RESET = 31'd1092;

  typedef enum logic [2:0] {
    CMD_WRITE_PARTICLE   = 3'd0,
    CMD_WRITE_CONSTRAINT = 3'd1,
    CMD_CLEAR_LAMBDAS    = 3'd2,
    CMD_SOLVE_PASS       = 3'd3,
    CMD_READ_PARTICLE    = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK            = 2'd0,
    STAT_BAD_INDEX     = 2'd1,
    STAT_BAD_ENDPOINTS = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_COMPLIANCE         = 2'd0,
    CFG_SUBSTEP_TIME       = 2'd1,
    CFG_CONSTRAINTS_IN_USE = 2'd2
  } cfg_reg_t;

  // One particle table entry.
  typedef struct packed {
    logic [30:0]        inv_mass;
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } particle_t;

  // One constraint table entry (the accumulated lambda lives in its own RAM).
  typedef struct packed {
    logic signed [31:0] dir_z;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_x;
    logic [30:0]        rest_length;
    logic [9:0]         second;
    logic [9:0]         first;
  } constraint_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== sv/xpbd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module xpbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/xpbd_div.sv =====
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// Depends on xpbd_pkg for the operand width.
module xpbd_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [xpbd_pkg::DIV_W-1:0] dividend,
  input  logic [xpbd_pkg::DIV_W-1:0] divisor,
  output logic                      busy,
  output logic                      done,
  output logic [xpbd_pkg::DIV_W-1:0] quotient
);
  import xpbd_pkg::*;

  logic [DIV_W:0]         rem;
  logic [DIV_W-1:0]       dsr;
  logic [$clog2(DIV_W)-1:0] cnt;
  logic [DIV_W:0]         rem_sh;
  logic [DIV_W+1:0]       diff;
  logic                   ge;

  // Shift in the next dividend bit and trial-subtract the divisor.
  always_comb begin
    rem_sh = {rem[DIV_W-1:0], quotient[DIV_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dsr};
    ge     = !diff[DIV_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= '0;
        quotient <= dividend;
        dsr      <= divisor;
        cnt      <= '0;
        busy     <= 1'b1;
      end else if (busy) begin
        rem      <= ge ? diff[DIV_W:0] : rem_sh;
        quotient <= {quotient[DIV_W-2:0], ge};
        cnt      <= cnt + 1'b1;
        if (cnt == $clog2(DIV_W)'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/xpbd_distance_constraint_solver_unit.sv =====
// Top level of the XPBD distance-constraint solver: command decode, table RAMs
// and the per-constraint projection sequencer. Depends on xpbd_pkg, xpbd_ram
// and xpbd_div.
//
//   Channel   Dir  Handshake                    Payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  tdata: command fields, tuser: command
//   m_axis    out  m_axis_tvalid/m_axis_tready  tdata: position and status
//   cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
// Clearing lambdas walks the lambda RAM one entry a cycle. A solve pass computes
// alpha, then per constraint runs the bitwise square root and up to four divisions
// on the shared one-bit-per-cycle divider. Reset is synchronous and clears control
// state only; the tables are undefined until written. A held result stalls the next
// command only at its own end.
module xpbd_distance_constraint_solver_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [11:0] index, [43:12] vec_x, [75:44] vec_y, [107:76] vec_z,
  // [138:108] inv_mass, [148:139] first_particle, [158:149] second_particle,
  // [189:159] rest_length, [191:190] zero
  input  logic [xpbd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [2:0] command
  input  logic [xpbd_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] out_x, [63:32] out_y, [95:64] out_z, [97:96] status, [103:98] zero
  output logic [xpbd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [xpbd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [xpbd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import xpbd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_RD_WAIT, ST_CLEAR, ST_AL_MUL, ST_AL_CHK,
    ST_C_ADDR, ST_C_DATA, ST_PA_DATA, ST_PB_DATA, ST_CHK, ST_SQ, ST_SQRT,
    ST_LAM_MUL, ST_LAM_NUM, ST_DIV, ST_UPD, ST_NEXT, ST_RESULT
  } state_t;

  typedef enum logic [2:0] {
    DIV_ALPHA, DIV_LAMBDA, DIV_GX, DIV_GY, DIV_GZ
  } div_sel_t;

  state_t   state;
  div_sel_t divsel;

  // Latched command.
  logic [2:0]         in_cmd;
  logic [11:0]        in_index;
  logic signed [31:0] in_x, in_y, in_z;
  logic [30:0]        in_w;
  logic [9:0]         in_first, in_second;
  logic [30:0]        in_rest;

  // Configuration registers.
  logic [30:0] compliance;
  logic [30:0] substep_time;
  logic [12:0] constraints_in_use;

  // Walk and projection state.
  logic [CIDX_W:0]    k;
  logic [CIDX_W:0]    n_walk;
  logic [30:0]        alpha;
  logic [9:0]         c_second;
  logic [30:0]        c_rest;
  logic signed [31:0] c_dir [3];
  logic signed [31:0] c_lam;
  logic signed [31:0] pa [3];
  logic signed [31:0] pb [3];
  logic [30:0]        wa, wb;
  logic signed [32:0] d [3];
  logic [63:0]        sum;
  logic [63:0]        sq_v;
  logic [31:0]        root;
  logic [34:0]        rem;
  logic [4:0]         cnt;
  logic [32:0]        len;
  logic               num_neg;
  logic signed [31:0] dl;
  logic signed [31:0] g [3];
  logic signed [31:0] s_w;
  logic signed [31:0] pn [3];
  logic               side;
  logic [2:0]         ustep;

  // Result staging and output register.
  logic signed [31:0] res_x, res_y, res_z;
  logic [1:0]         res_status;
  logic signed [31:0] o_x, o_y, o_z;
  logic [1:0]         o_status;

  // Shared multiplier.
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  // Divider interface.
  logic               div_start, div_busy, div_done;
  logic [DIV_W-1:0]   div_n, div_d, div_q;

  // RAM ports.
  logic               p_we;
  logic [PIDX_W-1:0]  p_waddr, p_raddr;
  particle_t          p_wdata, prd;
  logic [$bits(particle_t)-1:0] p_rdata;
  logic               c_we;
  constraint_t        c_wdata, crd;
  logic [$bits(constraint_t)-1:0] c_rdata;
  logic               lam_we;
  logic [CIDX_W-1:0]  lam_waddr;
  logic signed [31:0] lam_wdata;
  logic [31:0]        lam_rdata;

  // Datapath helpers.
  logic               accept;
  logic               p_idx_bad, c_idx_bad, ep_bad;
  logic [32:0]        d_abs [3];
  logic [31:0]        m_val [3];
  logic               sh;
  logic [32:0]        denom_c;
  logic [34:0]        rem_t, trial;
  logic signed [33:0] c_err;
  logic signed [63:0] num_c;
  logic [63:0]        num_mag;
  logic signed [31:0] dl_new;
  logic signed [31:0] mul_sh_sat;
  logic [30:0]        w_side;
  logic signed [31:0] pos_cur;
  logic signed [32:0] pos_sum;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = {6'b0, o_status, o_z, o_y, o_x};
  assign prd           = particle_t'(p_rdata);
  assign crd           = constraint_t'(c_rdata);

  // Range checks on the latched command.
  assign p_idx_bad = int'(in_index) >= PARTICLES;
  assign c_idx_bad = int'(in_index) >= CONSTRAINTS;
  assign ep_bad    = (in_first == in_second) || (int'(in_first) >= PARTICLES) ||
                     (int'(in_second) >= PARTICLES);

  // Deltas, overflow halving and magnitudes for the length.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_abs[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
    end
    sh = d_abs[0][32] | d_abs[0][31] | d_abs[1][32] | d_abs[1][31] |
         d_abs[2][32] | d_abs[2][31];
    for (int i = 0; i < 3; i++) begin
      m_val[i] = sh ? d_abs[i][32:1] : d_abs[i][31:0];
    end
  end

  assign denom_c = 33'(wa) + 33'(wb) + 33'(alpha);

  // One step of the bitwise integer square root.
  assign rem_t = {rem[32:0], sq_v[63:62]};
  assign trial = {1'b0, root, 2'b01};

  // Constraint error and lambda numerator.
  assign c_err   = $signed({1'b0, len}) - $signed({3'b000, c_rest});
  assign num_c   = -(64'(c_err) <<< FRACTION_BITS) - $signed(mul_p[63:0]);
  assign num_mag = num_c[63] ? 64'(-num_c) : 64'(num_c);

  // Signed, saturated lambda increment from the divider magnitude.
  always_comb begin
    if (!num_neg) begin
      dl_new = (div_q > 64'd2147483647) ? 32'sh7FFF_FFFF : div_q[31:0];
    end else begin
      dl_new = (div_q > 64'd2147483648) ? 32'sh8000_0000 : (~div_q[31:0]) + 32'd1;
    end
  end

  // Position update of the current side.
  assign mul_sh_sat = sat32(mul_p >>> FRACTION_BITS);
  assign w_side     = side ? wb : wa;
  always_comb begin
    case (ustep)
      3'd3:    pos_cur = side ? pb[0] : pa[0];
      3'd4:    pos_cur = side ? pb[1] : pa[1];
      default: pos_cur = side ? pb[2] : pa[2];
    endcase
    if (side) begin
      pos_sum = {pos_cur[31], pos_cur} - {mul_sh_sat[31], mul_sh_sat};
    end else begin
      pos_sum = {pos_cur[31], pos_cur} + {mul_sh_sat[31], mul_sh_sat};
    end
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_AL_MUL: begin
        mul_a = {2'b00, substep_time};
        mul_b = {2'b00, substep_time};
      end
      ST_SQ: begin
        case (cnt[1:0])
          2'd0: begin
            mul_a = {1'b0, m_val[0]};
            mul_b = {1'b0, m_val[0]};
          end
          2'd1: begin
            mul_a = {1'b0, m_val[1]};
            mul_b = {1'b0, m_val[1]};
          end
          2'd2: begin
            mul_a = {1'b0, m_val[2]};
            mul_b = {1'b0, m_val[2]};
          end
          default: ;
        endcase
      end
      ST_LAM_MUL: begin
        mul_a = {2'b00, alpha};
        mul_b = {c_lam[31], c_lam};
      end
      ST_UPD: begin
        case (ustep)
          3'd0: begin
            mul_a = {2'b00, w_side};
            mul_b = {dl[31], dl};
          end
          3'd2: begin
            mul_a = {g[0][31], g[0]};
            mul_b = {s_w[31], s_w};
          end
          3'd3: begin
            mul_a = {g[1][31], g[1]};
            mul_b = {s_w[31], s_w};
          end
          3'd4: begin
            mul_a = {g[2][31], g[2]};
            mul_b = {s_w[31], s_w};
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // RAM address and write control.
  always_comb begin
    p_we      = 1'b0;
    p_waddr   = in_index[PIDX_W-1:0];
    p_wdata   = '{inv_mass: in_w, z: in_z, y: in_y, x: in_x};
    p_raddr   = in_index[PIDX_W-1:0];
    c_we      = 1'b0;
    c_wdata   = '{dir_z: in_z, dir_y: in_y, dir_x: in_x, rest_length: in_rest,
                  second: in_second, first: in_first};
    lam_we    = 1'b0;
    lam_waddr = in_index[CIDX_W-1:0];
    lam_wdata = '0;
    case (state)
      ST_DECODE: begin
        if (in_cmd == CMD_WRITE_PARTICLE && !p_idx_bad) begin
          p_we = 1'b1;
        end
        if (in_cmd == CMD_WRITE_CONSTRAINT && !c_idx_bad && !ep_bad) begin
          c_we   = 1'b1;
          lam_we = 1'b1;
        end
      end
      ST_CLEAR: begin
        lam_we    = 1'b1;
        lam_waddr = k[CIDX_W-1:0];
      end
      ST_C_DATA: p_raddr = crd.first[PIDX_W-1:0];
      ST_PA_DATA: p_raddr = c_second[PIDX_W-1:0];
      ST_DIV: begin
        if (div_done && divsel == DIV_LAMBDA) begin
          lam_we    = 1'b1;
          lam_waddr = k[CIDX_W-1:0];
          lam_wdata = sat32(66'(c_lam) + 66'(dl_new));
        end
      end
      ST_UPD: begin
        if (ustep == 3'd6) begin
          p_we    = 1'b1;
          p_waddr = side ? c_second[PIDX_W-1:0] : p_waddr;
          p_wdata = '{inv_mass: w_side, z: pn[2], y: pn[1], x: pn[0]};
        end
      end
      default: ;
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      compliance         <= '0;
      substep_time       <= SUBSTEP_RESET;
      constraints_in_use <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COMPLIANCE:         compliance <= cfg_data;
        CFG_SUBSTEP_TIME:       substep_time <= cfg_data;
        CFG_CONSTRAINTS_IN_USE: constraints_in_use <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Endpoint a is kept apart from the write address mux above.
  logic [PIDX_W-1:0] a_idx;

  // Command sequencer and projection datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      div_start     <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            in_cmd    <= s_axis_tuser;
            in_index  <= s_axis_tdata[11:0];
            in_x      <= s_axis_tdata[43:12];
            in_y      <= s_axis_tdata[75:44];
            in_z      <= s_axis_tdata[107:76];
            in_w      <= s_axis_tdata[138:108];
            in_first  <= s_axis_tdata[148:139];
            in_second <= s_axis_tdata[158:149];
            in_rest   <= s_axis_tdata[189:159];
            state     <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          res_x      <= '0;
          res_y      <= '0;
          res_z      <= '0;
          res_status <= STAT_OK;
          state      <= ST_RESULT;
          case (in_cmd)
            CMD_WRITE_PARTICLE: begin
              if (p_idx_bad) res_status <= STAT_BAD_INDEX;
            end
            CMD_WRITE_CONSTRAINT: begin
              if (c_idx_bad) begin
                res_status <= STAT_BAD_INDEX;
              end else if (ep_bad) begin
                res_status <= STAT_BAD_ENDPOINTS;
              end
            end
            CMD_CLEAR_LAMBDAS: begin
              k     <= '0;
              state <= ST_CLEAR;
            end
            CMD_SOLVE_PASS: state <= ST_AL_MUL;
            CMD_READ_PARTICLE: begin
              if (p_idx_bad) begin
                res_status <= STAT_BAD_INDEX;
              end else begin
                state <= ST_RD_WAIT;
              end
            end
            default: ;
          endcase
        end
        ST_RD_WAIT: begin
          res_x <= prd.x;
          res_y <= prd.y;
          res_z <= prd.z;
          state <= ST_RESULT;
        end
        ST_CLEAR: begin
          if (k == (CIDX_W+1)'(CONSTRAINTS - 1)) begin
            state <= ST_RESULT;
          end
          k <= k + 1'b1;
        end
        // alpha = compliance * 2^(2F) / substep_time^2, saturated.
        ST_AL_MUL: state <= ST_AL_CHK;
        ST_AL_CHK: begin
          k      <= '0;
          n_walk <= (int'(constraints_in_use) > CONSTRAINTS) ?
                    (CIDX_W+1)'(CONSTRAINTS) : (CIDX_W+1)'(constraints_in_use);
          if (compliance == '0) begin
            alpha <= '0;
            state <= (constraints_in_use == '0) ? ST_RESULT : ST_C_ADDR;
          end else if (substep_time == '0) begin
            alpha <= ALPHA_MAX;
            state <= (constraints_in_use == '0) ? ST_RESULT : ST_C_ADDR;
          end else begin
            div_n     <= 64'(compliance) << (2 * FRACTION_BITS);
            div_d     <= mul_p[63:0];
            divsel    <= DIV_ALPHA;
            div_start <= 1'b1;
            state     <= ST_DIV;
          end
        end
        // Fetch the constraint, then both endpoints.
        ST_C_ADDR: state <= ST_C_DATA;
        ST_C_DATA: begin
          a_idx    <= crd.first[PIDX_W-1:0];
          c_second <= crd.second;
          c_rest   <= crd.rest_length;
          c_dir[0] <= crd.dir_x;
          c_dir[1] <= crd.dir_y;
          c_dir[2] <= crd.dir_z;
          c_lam    <= lam_rdata;
          state    <= ST_PA_DATA;
        end
        ST_PA_DATA: begin
          pa[0] <= prd.x;
          pa[1] <= prd.y;
          pa[2] <= prd.z;
          wa    <= prd.inv_mass;
          state <= ST_PB_DATA;
        end
        ST_PB_DATA: begin
          pb[0] <= prd.x;
          pb[1] <= prd.y;
          pb[2] <= prd.z;
          wb    <= prd.inv_mass;
          state <= ST_CHK;
        end
        // Skip a constraint whose denominator is zero.
        ST_CHK: begin
          for (int i = 0; i < 3; i++) begin
            d[i] <= {pa[i][31], pa[i]} - {pb[i][31], pb[i]};
          end
          sum <= '0;
          cnt <= '0;
          state <= (denom_c == '0) ? ST_NEXT : ST_SQ;
        end
        // Sum of squares, one product a cycle.
        ST_SQ: begin
          cnt <= cnt + 1'b1;
          if (cnt != '0) begin
            sum <= sum + mul_p[63:0];
          end
          if (cnt == 5'd3) begin
            sq_v  <= sum + mul_p[63:0];
            root  <= '0;
            rem   <= '0;
            cnt   <= '0;
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (rem_t >= trial) begin
            rem  <= rem_t - trial;
            root <= {root[30:0], 1'b1};
          end else begin
            rem  <= rem_t;
            root <= {root[30:0], 1'b0};
          end
          sq_v <= sq_v << 2;
          cnt  <= cnt + 1'b1;
          if (cnt == 5'd31) begin
            state <= ST_LAM_MUL;
          end
        end
        ST_LAM_MUL: begin
          len   <= sh ? {root, 1'b0} : {1'b0, root};
          state <= ST_LAM_NUM;
        end
        ST_LAM_NUM: begin
          num_neg   <= num_c[63];
          div_n     <= num_mag;
          div_d     <= 64'(denom_c);
          divsel    <= DIV_LAMBDA;
          div_start <= 1'b1;
          state     <= ST_DIV;
        end
        // Shared divider results: alpha, lambda step and the gradient.
        ST_DIV: begin
          if (div_done) begin
            case (divsel)
              DIV_ALPHA: begin
                alpha <= (div_q > 64'(ALPHA_MAX)) ? ALPHA_MAX : div_q[30:0];
                state <= (n_walk == '0) ? ST_RESULT : ST_C_ADDR;
              end
              DIV_LAMBDA: begin
                dl <= dl_new;
                if (len == '0) begin
                  g[0]  <= c_dir[0];
                  g[1]  <= c_dir[1];
                  g[2]  <= c_dir[2];
                  side  <= 1'b0;
                  ustep <= '0;
                  state <= ST_UPD;
                end else begin
                  div_n     <= 64'(d_abs[0]) << FRACTION_BITS;
                  div_d     <= 64'(len);
                  divsel    <= DIV_GX;
                  div_start <= 1'b1;
                end
              end
              DIV_GX: begin
                g[0]      <= d[0][32] ? (~div_q[31:0]) + 32'd1 : div_q[31:0];
                div_n     <= 64'(d_abs[1]) << FRACTION_BITS;
                divsel    <= DIV_GY;
                div_start <= 1'b1;
              end
              DIV_GY: begin
                g[1]      <= d[1][32] ? (~div_q[31:0]) + 32'd1 : div_q[31:0];
                div_n     <= 64'(d_abs[2]) << FRACTION_BITS;
                divsel    <= DIV_GZ;
                div_start <= 1'b1;
              end
              default: begin
                g[2]  <= d[2][32] ? (~div_q[31:0]) + 32'd1 : div_q[31:0];
                side  <= 1'b0;
                ustep <= '0;
                state <= ST_UPD;
              end
            endcase
          end
        end
        // Move endpoint a, then endpoint b, along the gradient.
        ST_UPD: begin
          ustep <= ustep + 1'b1;
          case (ustep)
            3'd0: begin
              if (w_side == '0) begin
                ustep <= '0;
                side  <= 1'b1;
                if (side) state <= ST_NEXT;
              end
            end
            3'd1: s_w <= mul_sh_sat;
            3'd3: pn[0] <= sat32(66'(pos_sum));
            3'd4: pn[1] <= sat32(66'(pos_sum));
            3'd5: pn[2] <= sat32(66'(pos_sum));
            3'd6: begin
              ustep <= '0;
              side  <= 1'b1;
              if (side) state <= ST_NEXT;
            end
            default: ;
          endcase
        end
        ST_NEXT: begin
          k <= k + 1'b1;
          state <= (k + 1'b1 >= n_walk) ? ST_RESULT : ST_C_ADDR;
        end
        // Hand the result to the output register once it is free.
        ST_RESULT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            o_x           <= res_x;
            o_y           <= res_y;
            o_z           <= res_z;
            o_status      <= res_status;
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Particle table: position and inverse mass.
  xpbd_ram #(
    .WIDTH($bits(particle_t)),
    .DEPTH(PARTICLES)
  ) u_particle_ram (
    .clk  (clk),
    .we   (p_we),
    .waddr((state == ST_UPD && !side) ? a_idx : p_waddr),
    .wdata(p_wdata),
    .raddr(p_raddr),
    .rdata(p_rdata)
  );

  // Constraint table: endpoints, rest length and rest direction.
  xpbd_ram #(
    .WIDTH($bits(constraint_t)),
    .DEPTH(CONSTRAINTS)
  ) u_constraint_ram (
    .clk  (clk),
    .we   (c_we),
    .waddr(in_index[CIDX_W-1:0]),
    .wdata(c_wdata),
    .raddr(k[CIDX_W-1:0]),
    .rdata(c_rdata)
  );

  // Accumulated lambda per constraint.
  xpbd_ram #(
    .WIDTH(32),
    .DEPTH(CONSTRAINTS)
  ) u_lambda_ram (
    .clk  (clk),
    .we   (lam_we),
    .waddr(lam_waddr),
    .wdata(lam_wdata),
    .raddr(k[CIDX_W-1:0]),
    .rdata(lam_rdata)
  );

  xpbd_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_n),
    .divisor (div_d),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(div_q)
  );

`ifndef SYNTHESIS
  // A command is taken only once; the block is busy the cycle after.
  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_axis_tready)
    else $error("input accepted twice in a row");

  // A division is never launched over one in flight.
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // Lambda writes happen only while a command is being worked on.
  a_lam_busy: assert property (@(posedge clk) disable iff (rst)
    lam_we |-> !s_axis_tready)
    else $error("lambda write while idle");

  // A pinned endpoint is never written back by the solver.
  a_pinned_kept: assert property (@(posedge clk) disable iff (rst)
    (p_we && state == ST_UPD) |-> (w_side != '0))
    else $error("pinned particle moved");

  // A finished result is loaded into the output register once it is free, and the block returns to idle.
  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT && (!m_axis_tvalid || m_axis_tready)) |=>
      (m_axis_tvalid && state == ST_IDLE))
    else $error("result not delivered");
`endif

endmodule
